FILE: hw/rtl/msu_pkg.sv
// Shared types, codes and constants of the motion fault supervisor.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package msu_pkg;

  // Width of the saturating immobility time counter
  localparam int STILL_W     = 16;
  // Width at which the counter is compared with the 16-bit limit
  localparam int STILL_CMP_W = (STILL_W > 16) ? STILL_W : 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [3:0] {
    OP_TICK         = 4'd0,
    OP_NOTHING      = 4'd1,
    OP_ERROR_EXIT   = 4'd2,
    OP_START        = 4'd3,
    OP_NEW_ORDER    = 4'd4,
    OP_BRAKING      = 4'd5,
    OP_ARRIVED      = 4'd6,
    OP_ERROR        = 4'd7,
    OP_STOP         = 4'd8,
    OP_ROUND_RETURN = 4'd9
  } op_t;

  typedef enum logic [2:0] {
    MODE_INIT  = 3'd0,
    MODE_IDLE  = 3'd1,
    MODE_TRAJ  = 3'd2,
    MODE_ERROR = 3'd3,
    MODE_ENDED = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ACK_NONE  = 3'd0,
    ACK_ASKED = 3'd1,
    ACK_BRAKE = 3'd2,
    ACK_ACKED = 3'd3,
    ACK_CALIB = 3'd4
  } ack_t;

  typedef enum logic [2:0] {
    WARN_NONE     = 3'd0,
    WARN_NEW_TRAJ = 3'd1,
    WARN_BRAKE    = 3'd2,
    WARN_ARRIVED  = 3'd3,
    WARN_CALIB    = 3'd4,
    WARN_ERROR    = 3'd5
  } warn_t;

  typedef enum logic [1:0] {
    CAUSE_NONE   = 2'd0,
    CAUSE_UNABLE = 2'd1,
    CAUSE_IMMOB  = 2'd2,
    CAUSE_ROUNDS = 2'd3
  } cause_t;

  typedef enum logic [2:0] {
    CFG_TRANS_ERR_LIMIT = 3'd0,
    CFG_ROT_ERR_LIMIT   = 3'd1,
    CFG_TRANS_STILL     = 3'd2,
    CFG_ROT_STILL       = 3'd3,
    CFG_IMMOB_LIMIT     = 3'd4,
    CFG_TICK_PERIOD     = 3'd5,
    CFG_MAX_ROUNDS      = 3'd6,
    CFG_CHECK_ENABLE    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [14:0] trans_error_limit;
    logic [14:0] rot_error_limit;
    logic [14:0] trans_still_speed;
    logic [14:0] rot_still_speed;
    logic [15:0] immobility_limit;
    logic [7:0]  tick_period;
    logic [7:0]  max_round_returns;
    logic        check_enable;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    trans_error_limit: 15'd1000,
    rot_error_limit:   15'd1000,
    trans_still_speed: 15'd40,
    rot_still_speed:   15'd40,
    immobility_limit:  16'd2000,
    tick_period:       8'd5,
    max_round_returns: 8'd10,
    check_enable:      1'b1
  };

  typedef struct packed {
    logic [3:0]         opcode;
    logic [2:0]         ack_kind;
    logic               trans_loop_on;
    logic               rot_loop_on;
    logic signed [15:0] trans_deviation;
    logic signed [15:0] rot_deviation;
    logic signed [15:0] trans_speed;
    logic signed [15:0] rot_speed;
    logic               has_arrived;
  } item_t;

  typedef struct packed {
    mode_t  mode;
    warn_t  warning_code;
    cause_t warning_source;
    cause_t fault_cause;
    logic   motion_reset;
    ack_t   ack_status;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/msu_cfg_regs.sv
// Configuration register bank of the motion fault supervisor.
// Depends on msu_pkg for the register indexes and the cfg_t layout.
`default_nettype none

module msu_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [msu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msu_pkg::CFG_DATA_W-1:0] cfg_data,
  output msu_pkg::cfg_t                  cfg
);
  import msu_pkg::*;

  // Write one register per enabled cycle, truncated to its width
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TRANS_ERR_LIMIT: cfg.trans_error_limit <= cfg_data[14:0];
        CFG_ROT_ERR_LIMIT:   cfg.rot_error_limit   <= cfg_data[14:0];
        CFG_TRANS_STILL:     cfg.trans_still_speed <= cfg_data[14:0];
        CFG_ROT_STILL:       cfg.rot_still_speed   <= cfg_data[14:0];
        CFG_IMMOB_LIMIT:     cfg.immobility_limit  <= cfg_data[15:0];
        CFG_TICK_PERIOD:     cfg.tick_period       <= cfg_data[7:0];
        CFG_MAX_ROUNDS:      cfg.max_round_returns <= cfg_data[7:0];
        CFG_CHECK_ENABLE:    cfg.check_enable      <= cfg_data[0];
        default:             cfg <= cfg;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/msu_in_stage.sv
// Input register of the motion fault supervisor: captures one request.
// Depends on msu_pkg for the item_t layout.
`default_nettype none

module msu_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  msu_pkg::item_t in_item,
  input  logic           take,
  output logic           stage_valid,
  output msu_pkg::item_t stage_item
);
  import msu_pkg::*;

  // Free when empty or when the held request moves on this cycle
  assign in_ready = !stage_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  // Capture payload on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/msu_core.sv
// Supervisor state and the single-pass event logic producing one result.
// Depends on msu_pkg for codes, cfg_t, item_t and result_t.
`default_nettype none

module msu_core (
  input  logic             clk,
  input  logic             rst,
  input  msu_pkg::cfg_t    cfg,
  input  msu_pkg::item_t   item,
  input  logic             advance,
  output msu_pkg::result_t result
);
  import msu_pkg::*;

  mode_t              sup_mode, sup_mode_next;
  ack_t               ack_tracker, ack_tracker_next;
  logic               error_sent, error_sent_next;
  cause_t             error_cause, error_cause_next;
  logic [STILL_W-1:0] still_time, still_time_next;
  logic [7:0]         round_returns, round_returns_next;

  warn_t  warn_code;
  cause_t warn_src;
  logic   pulse;

  logic [16:0]        trans_dev_mag, rot_dev_mag, trans_spd_mag, rot_spd_mag;
  logic               fault_unable, fault_immob, fault_rounds, any_fault;
  logic               still;
  logic [STILL_W:0]   still_sum;
  logic [STILL_W-1:0] still_acc, tick_still_time;
  cause_t             first_cause, last_cause;
  ack_t               ack_in;

  // Magnitude of a 16-bit two's complement value, 17 bits wide
  function automatic logic [16:0] mag16(input logic signed [15:0] v);
    logic [16:0] x;
    x = {v[15], v};
    return v[15] ? (17'd0 - x) : x;
  endfunction

  assign trans_dev_mag = mag16(item.trans_deviation);
  assign rot_dev_mag   = mag16(item.rot_deviation);
  assign trans_spd_mag = mag16(item.trans_speed);
  assign rot_spd_mag   = mag16(item.rot_speed);

  // Following error beyond limit on an active position loop
  assign fault_unable =
      (item.trans_loop_on && (trans_dev_mag > {2'b00, cfg.trans_error_limit})) ||
      (item.rot_loop_on   && (rot_dev_mag   > {2'b00, cfg.rot_error_limit}));

  // Still when not arrived and both speeds under four times their threshold
  assign still = !item.has_arrived &&
                 (trans_spd_mag < {cfg.trans_still_speed, 2'b00}) &&
                 (rot_spd_mag   < {cfg.rot_still_speed, 2'b00});

  // Accumulate still time, saturating at full scale
  assign still_sum = {1'b0, still_time} + (STILL_W + 1)'(cfg.tick_period);
  always_comb begin
    if (!still) begin
      still_acc = '0;
    end else if (still_sum[STILL_W]) begin
      still_acc = '1;
    end else begin
      still_acc = still_sum[STILL_W-1:0];
    end
  end

  assign fault_immob = STILL_CMP_W'(still_acc) > STILL_CMP_W'(cfg.immobility_limit);
  assign tick_still_time = fault_immob ? '0 : still_acc;
  assign fault_rounds = round_returns > cfg.max_round_returns;
  assign any_fault = fault_unable || fault_immob || fault_rounds;

  // First fault raises the warning, last one is left as the stored cause
  always_comb begin
    priority if (fault_unable) first_cause = CAUSE_UNABLE;
    else if (fault_immob)      first_cause = CAUSE_IMMOB;
    else                       first_cause = CAUSE_ROUNDS;
    priority if (fault_rounds) last_cause = CAUSE_ROUNDS;
    else if (fault_immob)      last_cause = CAUSE_IMMOB;
    else                       last_cause = CAUSE_UNABLE;
  end

  // Unknown acknowledge kinds are stored as none
  assign ack_in = (item.ack_kind > 3'(ACK_CALIB)) ? ACK_NONE : ack_t'(item.ack_kind);

  // Event decode: next state and warning for this request
  always_comb begin
    sup_mode_next      = sup_mode;
    ack_tracker_next   = ack_tracker;
    error_sent_next    = error_sent;
    error_cause_next   = error_cause;
    still_time_next    = still_time;
    round_returns_next = round_returns;
    warn_code          = WARN_NONE;
    warn_src           = CAUSE_NONE;
    pulse              = 1'b0;

    unique case (op_t'(item.opcode))
      OP_TICK: begin
        if (sup_mode != MODE_ERROR && cfg.check_enable) begin
          still_time_next = tick_still_time;
          if (any_fault) begin
            sup_mode_next    = MODE_ERROR;
            error_cause_next = last_cause;
            if (!error_sent) begin
              pulse            = 1'b1;
              warn_code        = WARN_ERROR;
              warn_src         = first_cause;
              ack_tracker_next = ACK_NONE;
              error_sent_next  = 1'b1;
            end
          end
        end
      end
      OP_NOTHING, OP_ERROR_EXIT, OP_START, OP_NEW_ORDER: begin
        round_returns_next = '0;
        error_sent_next    = 1'b0;
        error_cause_next   = CAUSE_NONE;
        still_time_next    = '0;
        if (op_t'(item.opcode) == OP_ERROR_EXIT || op_t'(item.opcode) == OP_START) begin
          sup_mode_next = MODE_IDLE;
        end
        if (op_t'(item.opcode) == OP_NEW_ORDER) begin
          ack_tracker_next = ack_in;
          warn_code        = WARN_NEW_TRAJ;
          sup_mode_next    = MODE_TRAJ;
        end
      end
      OP_BRAKING: begin
        if (ack_tracker == ACK_ASKED) begin
          warn_code        = WARN_BRAKE;
          warn_src         = error_cause;
          ack_tracker_next = ACK_BRAKE;
        end
      end
      OP_ARRIVED: begin
        if (ack_tracker != ACK_NONE && ack_tracker != ACK_ACKED) begin
          warn_code        = (ack_tracker == ACK_CALIB) ? WARN_CALIB : WARN_ARRIVED;
          warn_src         = error_cause;
          ack_tracker_next = ACK_ACKED;
        end
      end
      OP_ERROR: begin
        sup_mode_next = MODE_ERROR;
        if (!error_sent) begin
          pulse            = 1'b1;
          warn_code        = WARN_ERROR;
          warn_src         = error_cause;
          ack_tracker_next = ACK_NONE;
          error_sent_next  = 1'b1;
        end
      end
      OP_STOP: begin
        sup_mode_next = MODE_ENDED;
      end
      OP_ROUND_RETURN: begin
        if (round_returns != 8'hFF) begin
          round_returns_next = round_returns + 8'd1;
        end
      end
      default: begin
        sup_mode_next = sup_mode;
      end
    endcase
  end

  // Hold state; advance it once per processed request
  always_ff @(posedge clk) begin
    if (rst) begin
      sup_mode      <= MODE_INIT;
      ack_tracker   <= ACK_NONE;
      error_sent    <= 1'b0;
      error_cause   <= CAUSE_NONE;
      still_time    <= '0;
      round_returns <= '0;
    end else if (advance) begin
      sup_mode      <= sup_mode_next;
      ack_tracker   <= ack_tracker_next;
      error_sent    <= error_sent_next;
      error_cause   <= error_cause_next;
      still_time    <= still_time_next;
      round_returns <= round_returns_next;
    end
  end

  assign result.mode           = sup_mode_next;
  assign result.warning_code   = warn_code;
  assign result.warning_source = warn_src;
  assign result.fault_cause    = error_cause_next;
  assign result.motion_reset   = pulse;
  assign result.ack_status     = ack_tracker_next;

endmodule

`default_nettype wire

FILE: hw/rtl/motion_fault_supervisor_unit.sv
// Motion fault supervisor: one event request in, one result request out.
//
// Input channel (in_valid/in_ready) carries one event: opcode, acknowledge
// kind, loop enables, deviations, speeds and the arrival flag. Each accepted
// request produces exactly one result on the output channel
// (out_valid/out_ready): mode, warning code and source, stored fault cause,
// motion_reset pulse and acknowledge status.
// A request accepted into the input register passes on to the result
// register before its result shows. Throughput is one request per cycle
// while the receiver takes results; the only path between the registers
// is the event decode, a few 17-bit compares and the still-time adder.
// While the receiver stalls, the result register holds its value and the
// input register still takes one more request; in_ready falls only when both
// are full. Configuration writes (cfg_we, cfg_index, cfg_data) take effect
// at the next edge and belong in idle periods.
// Reset (rst, synchronous) empties both registers, returns the supervisor
// to init with no acknowledge, no cause and cleared counters, and restores
// the configuration defaults.
`default_nettype none

module motion_fault_supervisor_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [msu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msu_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [3:0]                     opcode,
  input  logic [2:0]                     ack_kind,
  input  logic                           trans_loop_on,
  input  logic                           rot_loop_on,
  input  logic signed [15:0]             trans_deviation,
  input  logic signed [15:0]             rot_deviation,
  input  logic signed [15:0]             trans_speed,
  input  logic signed [15:0]             rot_speed,
  input  logic                           has_arrived,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     mode,
  output logic [2:0]                     warning_code,
  output logic [1:0]                     warning_source,
  output logic [1:0]                     fault_cause,
  output logic                           motion_reset,
  output logic [2:0]                     ack_status
);
  import msu_pkg::*;

  cfg_t    cfg;
  item_t   in_item, stage_item;
  logic    stage_valid, take;
  result_t core_result, out_result;

  assign in_item = '{
    opcode:          opcode,
    ack_kind:        ack_kind,
    trans_loop_on:   trans_loop_on,
    rot_loop_on:     rot_loop_on,
    trans_deviation: trans_deviation,
    rot_deviation:   rot_deviation,
    trans_speed:     trans_speed,
    rot_speed:       rot_speed,
    has_arrived:     has_arrived
  };

  msu_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  msu_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .take        (take),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  // Advance the held request when the result register is free
  assign take = stage_valid && (!out_valid || out_ready);

  msu_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item    (stage_item),
    .advance (take),
    .result  (core_result)
  );

  // Result register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_result <= core_result;
    end
  end

  assign mode           = out_result.mode;
  assign warning_code   = out_result.warning_code;
  assign warning_source = out_result.warning_source;
  assign fault_cause    = out_result.fault_cause;
  assign motion_reset   = out_result.motion_reset;
  assign ack_status     = out_result.ack_status;

endmodule

`default_nettype wire

FILE: hw/rtl/msu_checker.sv
// Port-level checks for the motion fault supervisor, bound to the top level.
// Depends on msu_pkg for the mode, warning and cause codes.
`default_nettype none

module msu_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] mode,
  input logic [2:0] warning_code,
  input logic [1:0] warning_source,
  input logic [1:0] fault_cause,
  input logic       motion_reset
);
  import msu_pkg::*;

  // Motion reset only comes with the error warning in error mode
  a_pulse_is_error: assert property (@(posedge clk) disable iff (rst)
    (out_valid && motion_reset) |->
      (warning_code == 3'(WARN_ERROR) && mode == 3'(MODE_ERROR)))
    else $error("motion_reset without error warning");

  // No warning carries no source
  a_quiet_no_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && warning_code == 3'(WARN_NONE)) |->
      (warning_source == 2'(CAUSE_NONE)))
    else $error("source reported without warning");

  // A new order starts a trajectory with the cause cleared
  a_new_traj_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && warning_code == 3'(WARN_NEW_TRAJ)) |->
      (mode == 3'(MODE_TRAJ) && fault_cause == 2'(CAUSE_NONE)))
    else $error("new trajectory warning with bad mode or cause");

  // Stalled result holds
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(mode) &&
      $stable(warning_code) && $stable(fault_cause)))
    else $error("stalled result changed");

endmodule

bind motion_fault_supervisor_unit msu_checker u_msu_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .mode           (mode),
  .warning_code   (warning_code),
  .warning_source (warning_source),
  .fault_cause    (fault_cause),
  .motion_reset   (motion_reset)
);

`default_nettype wire

FILE: test/tb_motion_fault_supervisor_unit.sv
// Testbench for motion_fault_supervisor_unit: directed table, then random event streams.
// Checks typed rows against their table outcome, all else against an in-bench model.
// Depends on msu_pkg and the unit under test only.
`timescale 1ns / 1ps

module tb_motion_fault_supervisor_unit;
  import msu_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_PAUSE   = 10;
  localparam int STYLE_MIX     = 0;
  localparam int STYLE_SATURATE = 1;

  // Codes outside the defined ranges and the 16-bit signed extremes
  localparam logic [3:0] OP_UNUSED_TOP  = 4'd15;
  localparam logic [2:0] ACK_UNUSED_TOP = 3'd7;
  localparam logic [15:0] S16_MAX = 16'h7FFF;
  localparam logic [15:0] S16_MIN = 16'h8000;

  typedef struct packed {
    item_t   ev;
    logic    typed;
    result_t want;
  } row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  cfg_idx_t   cfg_index = CFG_TRANS_ERR_LIMIT;
  logic [15:0] cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  item_t      drive_ev = '0;
  logic       row_typed = 1'b0;
  result_t    row_want = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] mode;
  logic [2:0] warning_code;
  logic [1:0] warning_source;
  logic [1:0] fault_cause;
  logic       motion_reset;
  logic [2:0] ack_status;

  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 52;
  int unsigned cycle_count = 0;
  bit          failed = 1'b0;

  // Supervisor model state and its copy of the settings
  cfg_t        cfg_copy = CFG_RESET;
  mode_t       mode_now = MODE_INIT;
  ack_t        ack_now = ACK_NONE;
  logic        fault_latched = 1'b0;
  cause_t      cause_now = CAUSE_NONE;
  logic [STILL_W-1:0] still_time_now = '0;
  logic [7:0]  round_count_now = '0;

  result_t report_q[$];
  row_t    directed_rows[$];

  motion_fault_supervisor_unit u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (drive_ev.opcode),
    .ack_kind        (drive_ev.ack_kind),
    .trans_loop_on   (drive_ev.trans_loop_on),
    .rot_loop_on     (drive_ev.rot_loop_on),
    .trans_deviation (drive_ev.trans_deviation),
    .rot_deviation   (drive_ev.rot_deviation),
    .trans_speed     (drive_ev.trans_speed),
    .rot_speed       (drive_ev.rot_speed),
    .has_arrived     (drive_ev.has_arrived),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .mode            (mode),
    .warning_code    (warning_code),
    .warning_source  (warning_source),
    .fault_cause     (fault_cause),
    .motion_reset    (motion_reset),
    .ack_status      (ack_status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("motion_fault_supervisor_unit test failed");
      $finish;
    end
  end

  function automatic logic [16:0] magnitude(input logic [15:0] v);
    return v[15] ? 17'h10000 - {1'b0, v} : {1'b0, v};
  endfunction

  // First fault of an episode warns and pulses; later ones only hold error mode
  function automatic void raise_fault(inout result_t r);
    if (!fault_latched) begin
      r.motion_reset   = 1'b1;
      r.warning_code   = WARN_ERROR;
      r.warning_source = cause_now;
      ack_now          = ACK_NONE;
      fault_latched    = 1'b1;
    end
    mode_now = MODE_ERROR;
  endfunction

  function automatic void clear_episode();
    round_count_now = '0;
    fault_latched   = 1'b0;
    cause_now       = CAUSE_NONE;
    still_time_now  = '0;
  endfunction

  // Advance the supervisor model by one request and return its report
  function automatic result_t predict_supervisor(input item_t ev);
    result_t          r;
    logic [STILL_W:0] still_sum;
    logic             still;
    r = '0;
    r.warning_code   = WARN_NONE;
    r.warning_source = CAUSE_NONE;
    r.motion_reset   = 1'b0;
    case (ev.opcode)
      OP_TICK: begin
        if (mode_now != MODE_ERROR && cfg_copy.check_enable) begin
          if ((ev.trans_loop_on &&
               magnitude(ev.trans_deviation) > {2'b0, cfg_copy.trans_error_limit}) ||
              (ev.rot_loop_on &&
               magnitude(ev.rot_deviation) > {2'b0, cfg_copy.rot_error_limit})) begin
            cause_now = CAUSE_UNABLE;
            raise_fault(r);
          end
          still = !ev.has_arrived &&
                  magnitude(ev.trans_speed) < {cfg_copy.trans_still_speed, 2'b00} &&
                  magnitude(ev.rot_speed) < {cfg_copy.rot_still_speed, 2'b00};
          if (still) begin
            still_sum = {1'b0, still_time_now} + (STILL_W + 1)'(cfg_copy.tick_period);
            still_time_now = still_sum[STILL_W] ? '1 : still_sum[STILL_W-1:0];
          end else begin
            still_time_now = '0;
          end
          if (STILL_CMP_W'(still_time_now) > STILL_CMP_W'(cfg_copy.immobility_limit)) begin
            still_time_now = '0;
            cause_now = CAUSE_IMMOB;
            raise_fault(r);
          end
          if (round_count_now > cfg_copy.max_round_returns) begin
            cause_now = CAUSE_ROUNDS;
            raise_fault(r);
          end
        end
      end
      OP_NOTHING: clear_episode();
      OP_ERROR_EXIT, OP_START: begin
        clear_episode();
        mode_now = MODE_IDLE;
      end
      OP_NEW_ORDER: begin
        ack_now = (ev.ack_kind > ACK_CALIB) ? ACK_NONE : ack_t'(ev.ack_kind);
        clear_episode();
        r.warning_code   = WARN_NEW_TRAJ;
        r.warning_source = cause_now;
        mode_now = MODE_TRAJ;
      end
      OP_BRAKING: begin
        if (ack_now == ACK_ASKED) begin
          r.warning_code   = WARN_BRAKE;
          r.warning_source = cause_now;
          ack_now = ACK_BRAKE;
        end
      end
      OP_ARRIVED: begin
        if (ack_now != ACK_NONE && ack_now != ACK_ACKED) begin
          r.warning_code   = (ack_now == ACK_CALIB) ? WARN_CALIB : WARN_ARRIVED;
          r.warning_source = cause_now;
          ack_now = ACK_ACKED;
        end
      end
      OP_ERROR: raise_fault(r);
      OP_STOP: mode_now = MODE_ENDED;
      OP_ROUND_RETURN: begin
        if (round_count_now != 8'hFF) round_count_now = round_count_now + 8'd1;
      end
      default: ;
    endcase
    r.mode        = mode_now;
    r.fault_cause = cause_now;
    r.ack_status  = ack_now;
    return r;
  endfunction

  function automatic void check_field(input string what, input logic [2:0] want,
                                      input logic [2:0] seen);
    if (seen !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, what, want, seen);
      failed = 1'b1;
    end
  endfunction

  // Receiver: stall at random
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each delivered report, then predict for each accepted request
  always @(posedge clk) begin
    result_t want;
    result_t calc;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (report_q.size() == 0) begin
          $display("%0t: report delivered with none outstanding", $time);
          failed = 1'b1;
        end else begin
          want = report_q.pop_front();
          check_field("mode", want.mode, mode);
          check_field("warning_code", want.warning_code, warning_code);
          check_field("warning_source", 3'(want.warning_source), 3'(warning_source));
          check_field("fault_cause", 3'(want.fault_cause), 3'(fault_cause));
          check_field("motion_reset", 3'(want.motion_reset), 3'(motion_reset));
          check_field("ack_status", want.ack_status, ack_status);
        end
      end
      if (in_valid && in_ready) begin
        calc = predict_supervisor(drive_ev);
        report_q.push_back(row_typed ? row_want : calc);
      end
    end
  end

  function automatic item_t make_request(input logic [3:0] op, input logic [2:0] ack,
                                         input logic tl, input logic rl,
                                         input logic [15:0] td, input logic [15:0] rd,
                                         input logic [15:0] ts, input logic [15:0] rs,
                                         input logic arr);
    item_t e;
    e.opcode          = op;
    e.ack_kind        = ack;
    e.trans_loop_on   = tl;
    e.rot_loop_on     = rl;
    e.trans_deviation = td;
    e.rot_deviation   = rd;
    e.trans_speed     = ts;
    e.rot_speed       = rs;
    e.has_arrived     = arr;
    return e;
  endfunction

  function automatic result_t outcome(input mode_t m, input warn_t w, input cause_t s,
                                      input cause_t c, input logic p, input ack_t a);
    return '{m, w, s, c, p, a};
  endfunction

  // Signed value whose magnitude sits below, at or just over a threshold, or a random value
  function automatic logic [15:0] near_bound(input logic [16:0] bound);
    int unsigned k;
    logic [16:0] mag;
    k = $urandom_range(9);
    if (k < 6) mag = 17'($urandom_range(bound));
    else if (k == 6) mag = (bound == '0) ? '0 : bound - 17'd1;
    else if (k == 7) mag = bound;
    else if (k == 8) mag = bound + 17'd1;
    else return 16'($urandom);
    if (mag > 17'h08000) return 16'($urandom);
    return $urandom_range(1) ? 16'h0000 - mag[15:0] : mag[15:0];
  endfunction

  function automatic item_t random_request(input int style, input int idx);
    item_t       e;
    logic [95:0] noise;
    int unsigned p;
    noise = {$urandom, $urandom, $urandom};
    e = noise[$bits(item_t)-1:0];
    if (style == STYLE_SATURATE) begin
      // Interleave still ticks and round returns with no episode reset
      if (idx == 0) begin
        e.opcode = OP_START;
      end else if (idx % 2 == 1) begin
        e.opcode = OP_TICK;
        e.has_arrived = 1'b0;
        if (e.trans_deviation == S16_MIN) e.trans_deviation = S16_MAX;
        if (e.rot_deviation == S16_MIN) e.rot_deviation = S16_MAX;
      end else begin
        e.opcode = OP_ROUND_RETURN;
      end
      return e;
    end
    p = $urandom_range(99);
    if (p < 40) begin
      e.opcode          = OP_TICK;
      e.trans_deviation = near_bound({2'b0, cfg_copy.trans_error_limit});
      e.rot_deviation   = near_bound({2'b0, cfg_copy.rot_error_limit});
      e.trans_speed     = near_bound({cfg_copy.trans_still_speed, 2'b00});
      e.rot_speed       = near_bound({cfg_copy.rot_still_speed, 2'b00});
      e.has_arrived     = ($urandom_range(9) == 0);
    end else if (p < 52) begin
      e.opcode = OP_NEW_ORDER;
      if ($urandom_range(7) != 0) e.ack_kind = 3'($urandom_range(ACK_CALIB));
    end else if (p < 62) e.opcode = OP_BRAKING;
    else if (p < 72) e.opcode = OP_ARRIVED;
    else if (p < 80) e.opcode = OP_ROUND_RETURN;
    else if (p < 84) e.opcode = OP_ERROR;
    else if (p < 88) e.opcode = OP_START;
    else if (p < 91) e.opcode = OP_ERROR_EXIT;
    else if (p < 93) e.opcode = OP_NOTHING;
    else if (p < 95) e.opcode = OP_STOP;
    else if (p < 97) e.opcode = 4'($urandom_range(OP_UNUSED_TOP, OP_ROUND_RETURN + 1));
    return e;
  endfunction

  function automatic cfg_t random_settings(input int unsigned immob_max);
    cfg_t c;
    c.trans_error_limit = 15'($urandom_range(1500));
    c.rot_error_limit   = 15'($urandom_range(1500));
    c.trans_still_speed = 15'($urandom_range(100));
    c.rot_still_speed   = 15'($urandom_range(100));
    c.immobility_limit  = 16'($urandom_range(immob_max));
    c.tick_period       = 8'($urandom_range(255));
    c.max_round_returns = 8'($urandom_range(12));
    c.check_enable      = 1'b1;
    return c;
  endfunction

  // Present one request and hold it until accepted
  task automatic send_request(input item_t e, input logic typed, input result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    drive_ev  <= e;
    row_typed <= typed;
    row_want  <= want;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [15:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_TRANS_ERR_LIMIT: cfg_copy.trans_error_limit = data[14:0];
      CFG_ROT_ERR_LIMIT:   cfg_copy.rot_error_limit   = data[14:0];
      CFG_TRANS_STILL:     cfg_copy.trans_still_speed = data[14:0];
      CFG_ROT_STILL:       cfg_copy.rot_still_speed   = data[14:0];
      CFG_IMMOB_LIMIT:     cfg_copy.immobility_limit  = data;
      CFG_TICK_PERIOD:     cfg_copy.tick_period       = data[7:0];
      CFG_MAX_ROUNDS:      cfg_copy.max_round_returns = data[7:0];
      CFG_CHECK_ENABLE:    cfg_copy.check_enable      = data[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (report_q.size() != 0) @(posedge clk);
  endtask

  // Drain, then rewrite every register; unused upper data bits carry noise
  task automatic apply_settings(input cfg_t c);
    wait_drained();
    cfg_write(CFG_TRANS_ERR_LIMIT, {1'($urandom), c.trans_error_limit});
    cfg_write(CFG_ROT_ERR_LIMIT, {1'($urandom), c.rot_error_limit});
    cfg_write(CFG_TRANS_STILL, {1'($urandom), c.trans_still_speed});
    cfg_write(CFG_ROT_STILL, {1'($urandom), c.rot_still_speed});
    cfg_write(CFG_IMMOB_LIMIT, c.immobility_limit);
    cfg_write(CFG_TICK_PERIOD, {8'($urandom), c.tick_period});
    cfg_write(CFG_MAX_ROUNDS, {8'($urandom), c.max_round_returns});
    cfg_write(CFG_CHECK_ENABLE, {15'($urandom), c.check_enable});
    cfg_we <= 1'b0;
  endtask

  task automatic run_random(input int count, input int style);
    for (int i = 0; i < count; i++) send_request(random_request(style, i), 1'b0, '0);
    in_valid <= 1'b0;
  endtask

  initial begin
    cfg_t set;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Lower the immobility and round-return ceilings so the table reaches them
    cfg_write(CFG_IMMOB_LIMIT, 16'd5);
    cfg_write(CFG_MAX_ROUNDS, 16'd1);
    cfg_we <= 1'b0;

    directed_rows.push_back('{make_request(OP_TICK, ACK_NONE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      outcome(MODE_INIT, WARN_NONE, CAUSE_NONE, CAUSE_NONE, 0, ACK_NONE)});
    directed_rows.push_back('{make_request(OP_NEW_ORDER, ACK_ASKED, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      outcome(MODE_TRAJ, WARN_NEW_TRAJ, CAUSE_NONE, CAUSE_NONE, 0, ACK_ASKED)});
    directed_rows.push_back('{make_request(OP_BRAKING, ACK_NONE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      outcome(MODE_TRAJ, WARN_BRAKE, CAUSE_NONE, CAUSE_NONE, 0, ACK_BRAKE)});
    directed_rows.push_back('{make_request(OP_ARRIVED, ACK_NONE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      outcome(MODE_TRAJ, WARN_ARRIVED, CAUSE_NONE, CAUSE_NONE, 0, ACK_ACKED)});
    directed_rows.push_back('{make_request(OP_ARRIVED, ACK_NONE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      outcome(MODE_TRAJ, WARN_NONE, CAUSE_NONE, CAUSE_NONE, 0, ACK_ACKED)});
    // Following error at the most negative deviation
    directed_rows.push_back('{make_request(OP_TICK, ACK_NONE, 1, 0, S16_MIN, S16_MAX,
      S16_MAX, 0, 0), 1'b1,
      outcome(MODE_ERROR, WARN_ERROR, CAUSE_UNABLE, CAUSE_UNABLE, 1, ACK_NONE)});
    // Ticks are ignored while in error
    directed_rows.push_back('{make_request(OP_TICK, ACK_NONE, 1, 1, S16_MAX, S16_MIN,
      0, 0, 1), 1'b1,
      outcome(MODE_ERROR, WARN_NONE, CAUSE_NONE, CAUSE_UNABLE, 0, ACK_NONE)});
    // External error after one already sent: no second warning
    directed_rows.push_back('{make_request(OP_ERROR, ACK_NONE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      outcome(MODE_ERROR, WARN_NONE, CAUSE_NONE, CAUSE_UNABLE, 0, ACK_NONE)});
    directed_rows.push_back('{make_request(OP_START, ACK_NONE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      outcome(MODE_IDLE, WARN_NONE, CAUSE_NONE, CAUSE_NONE, 0, ACK_NONE)});
    // Unknown acknowledge kind is stored as none
    directed_rows.push_back('{make_request(OP_NEW_ORDER, ACK_UNUSED_TOP, 0, 0, 0, 0, 0, 0, 0),
      1'b1, outcome(MODE_TRAJ, WARN_NEW_TRAJ, CAUSE_NONE, CAUSE_NONE, 0, ACK_NONE)});
    directed_rows.push_back('{make_request(OP_ARRIVED, ACK_NONE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      outcome(MODE_TRAJ, WARN_NONE, CAUSE_NONE, CAUSE_NONE, 0, ACK_NONE)});
    directed_rows.push_back('{make_request(OP_NEW_ORDER, ACK_CALIB, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      outcome(MODE_TRAJ, WARN_NEW_TRAJ, CAUSE_NONE, CAUSE_NONE, 0, ACK_CALIB)});
    directed_rows.push_back('{make_request(OP_BRAKING, ACK_NONE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      outcome(MODE_TRAJ, WARN_NONE, CAUSE_NONE, CAUSE_NONE, 0, ACK_CALIB)});
    directed_rows.push_back('{make_request(OP_ARRIVED, ACK_NONE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      outcome(MODE_TRAJ, WARN_CALIB, CAUSE_NONE, CAUSE_NONE, 0, ACK_ACKED)});
    // External error opens an episode with no stored cause
    directed_rows.push_back('{make_request(OP_ERROR, ACK_NONE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      outcome(MODE_ERROR, WARN_ERROR, CAUSE_NONE, CAUSE_NONE, 1, ACK_NONE)});
    directed_rows.push_back('{make_request(OP_ERROR_EXIT, ACK_NONE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      outcome(MODE_IDLE, WARN_NONE, CAUSE_NONE, CAUSE_NONE, 0, ACK_NONE)});
    directed_rows.push_back('{make_request(OP_TICK, ACK_NONE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      outcome(MODE_IDLE, WARN_NONE, CAUSE_NONE, CAUSE_NONE, 0, ACK_NONE)});
    directed_rows.push_back('{make_request(OP_ROUND_RETURN, ACK_NONE, 0, 0, 0, 0, 0, 0, 0),
      1'b1, outcome(MODE_IDLE, WARN_NONE, CAUSE_NONE, CAUSE_NONE, 0, ACK_NONE)});
    directed_rows.push_back('{make_request(OP_ROUND_RETURN, ACK_NONE, 0, 0, 0, 0, 0, 0, 0),
      1'b1, outcome(MODE_IDLE, WARN_NONE, CAUSE_NONE, CAUSE_NONE, 0, ACK_NONE)});
    // All three faults in one tick: first one warns, last one is stored
    directed_rows.push_back('{make_request(OP_TICK, ACK_NONE, 1, 1, S16_MAX, S16_MIN,
      0, 0, 0), 1'b1,
      outcome(MODE_ERROR, WARN_ERROR, CAUSE_UNABLE, CAUSE_ROUNDS, 1, ACK_NONE)});
    directed_rows.push_back('{make_request(OP_NOTHING, ACK_NONE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      outcome(MODE_ERROR, WARN_NONE, CAUSE_NONE, CAUSE_NONE, 0, ACK_NONE)});
    directed_rows.push_back('{make_request(OP_UNUSED_TOP, ACK_UNUSED_TOP, 1, 1, S16_MIN,
      S16_MIN, S16_MIN, S16_MIN, 1), 1'b1,
      outcome(MODE_ERROR, WARN_NONE, CAUSE_NONE, CAUSE_NONE, 0, ACK_NONE)});
    directed_rows.push_back('{make_request(OP_STOP, ACK_NONE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
      outcome(MODE_ENDED, WARN_NONE, CAUSE_NONE, CAUSE_NONE, 0, ACK_NONE)});
    // Deviations on and just over the limit, speeds at the extremes and just under still speed
    directed_rows.push_back('{make_request(OP_TICK, ACK_NONE, 1, 1, 16'd1000, -16'sd1000,
      S16_MIN, S16_MIN, 1), 1'b0, '0});
    directed_rows.push_back('{make_request(OP_TICK, ACK_UNUSED_TOP, 1, 1, 16'd1001,
      -16'sd1001, 16'd159, -16'sd159, 0), 1'b0, '0});

    foreach (directed_rows[i])
      send_request(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
    in_valid <= 1'b0;

    // Sender idles less than the receiver
    apply_settings(CFG_RESET);
    run_random(50, STYLE_MIX);
    set = '0;
    set.check_enable = 1'b1;
    apply_settings(set);
    run_random(35, STYLE_MIX);
    apply_settings(random_settings(300));
    run_random(40, STYLE_MIX);

    // Receiver idles less than the sender
    send_idle_pct = 52;
    recv_idle_pct = 36;
    set = random_settings(300);
    set.check_enable = 1'b0;
    apply_settings(set);
    run_random(35, STYLE_MIX);
    apply_settings(random_settings(40));
    run_random(40, STYLE_MIX);

    // Full rate, every setting at its top: drive both counters into saturation
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set = '1;
    apply_settings(set);
    run_random(520, STYLE_SATURATE);

    wait_drained();
    repeat (DRAIN_PAUSE) @(posedge clk);
    if (!failed && report_q.size() == 0) begin
      $display("motion_fault_supervisor_unit test passed");
    end else begin
      $display("motion_fault_supervisor_unit test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/msu_pkg.sv
hw/rtl/msu_cfg_regs.sv
hw/rtl/msu_in_stage.sv
hw/rtl/msu_core.sv
hw/rtl/motion_fault_supervisor_unit.sv
hw/rtl/msu_checker.sv
test/tb_motion_fault_supervisor_unit.sv
